// ===== src/ssns_pkg.sv =====
// package for the seven-segment number serializer
// holds widths, segment patterns and elaboration-time helpers; no dependencies
`default_nettype none

package ssns_pkg;

  localparam int VALUE_W        = 20;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 8;
  localparam int NUM_DIGITS_DEF = 6;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 3;

  localparam logic [BYTE_W-1:0] BLANK_BYTE = 8'hFF;

  // active-low segment pattern for one decimal digit
  function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] digit);
    logic [BYTE_W-1:0] code;
    case (digit)
      4'd0:    code = 8'h40;
      4'd1:    code = 8'hF8;
      4'd2:    code = 8'h24;
      4'd3:    code = 8'h30;
      4'd4:    code = 8'h98;
      4'd5:    code = 8'h12;
      4'd6:    code = 8'h02;
      4'd7:    code = 8'h78;
      4'd8:    code = 8'h00;
      4'd9:    code = 8'h10;
      default: code = BLANK_BYTE;
    endcase
    return code;
  endfunction

  // largest number that fits in the given count of decimal digits
  function automatic longint unsigned max_shown(input int digits);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < digits; i++) begin
      p = p * 10;
    end
    return p - 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssns_digit.sv =====
// one decimal digit step: splits a number into quotient and remainder by ten
// and encodes the remainder as a segment byte; uses ssns_pkg
`default_nettype none

module ssns_digit (
  input  wire logic [ssns_pkg::VALUE_W-1:0] x,
  input  wire logic                         show,
  output logic      [ssns_pkg::VALUE_W-1:0] q,
  output logic      [ssns_pkg::BYTE_W-1:0]  seg
);
  import ssns_pkg::*;

  // reciprocal of ten, scaled by 2^23; exact for every 20-bit input
  localparam logic [VALUE_W-1:0] RECIP10 = 20'd838861;
  localparam int                 SHIFT   = 23;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   q10;
  logic [VALUE_W-1:0]   rem_full;

  assign prod     = {{VALUE_W{1'b0}}, x} * {{VALUE_W{1'b0}}, RECIP10};
  assign q        = VALUE_W'(prod[2*VALUE_W-1:SHIFT]);
  assign q10      = VALUE_W'({q, 3'b000}) + VALUE_W'({q, 1'b0});
  assign rem_full = x - q10;
  assign seg      = show ? seg_code(rem_full[3:0]) : BLANK_BYTE;

endmodule

`default_nettype wire

// ===== src/seven_segment_number_serializer_top.sv =====
// seven-segment number serializer, top level
// the number passes from the input register into the shifter, whose top bit is the serial bit
// throughput: NUM_DIGITS bytes per number, one bit per cycle while out_tready is high;
//   the next number waits in the input register
// digits are worked out one per byte while the previous byte shifts out
// reset: synchronous active-low rst_n empties the input register and the shifter
`default_nettype none

module seven_segment_number_serializer_top #(
  parameter int NUM_DIGITS = ssns_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ssns_pkg::IN_TDATA_W-1:0]    in_tdata,   // [19:0] value
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [ssns_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] serial_bit
  output logic                                    out_tuser,  // [0] latch_strobe
  output logic                                    out_tlast   // last bit of the run
);
  import ssns_pkg::*;

  localparam int                POS_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(NUM_DIGITS - 1);
  localparam longint unsigned   MAX_VALUE = max_shown(NUM_DIGITS);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = '1;

  // input register
  logic               vld_r, vld_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;

  // serializer state
  logic                 busy_r, busy_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [VALUE_W-1:0]   rest_r, rest_nxt;
  logic                 showing_r, showing_nxt;
  logic                 over_r, over_nxt;

  logic               in_accept;
  logic               load;
  logic               step;
  logic               byte_end;
  logic               over_in;
  logic               over_cur;
  logic [VALUE_W-1:0] dig_x;
  logic               dig_show;
  logic [VALUE_W-1:0] dig_q;
  logic [BYTE_W-1:0]  dig_seg;
  logic [BYTE_W-1:0]  new_byte;

  assign byte_end  = (bit_cnt_r == LAST_BIT);
  assign load      = vld_r && (!busy_r || (out_tready && byte_end && pos_r == LAST_POS));
  assign in_tready = !vld_r || load;
  assign in_accept = in_tvalid && in_tready;
  assign step      = busy_r && out_tready;

  assign over_in  = (64'(value_r) > MAX_VALUE);
  assign over_cur = load ? over_in : over_r;
  assign dig_x    = load ? value_r : rest_r;
  assign dig_show = load ? 1'b1 : showing_r;
  assign new_byte = over_cur ? BLANK_BYTE : dig_seg;

  ssns_digit u_digit (
    .x    (dig_x),
    .show (dig_show),
    .q    (dig_q),
    .seg  (dig_seg)
  );

  always_comb begin
    vld_nxt     = vld_r;
    value_nxt   = value_r;
    busy_nxt    = busy_r;
    byte_nxt    = byte_r;
    bit_cnt_nxt = bit_cnt_r;
    pos_nxt     = pos_r;
    rest_nxt    = rest_r;
    showing_nxt = showing_r;
    over_nxt    = over_r;

    if (load) begin
      vld_nxt = 1'b0;
    end
    if (in_accept) begin
      vld_nxt   = 1'b1;
      value_nxt = in_tdata[VALUE_W-1:0];
    end

    if (load) begin
      busy_nxt    = 1'b1;
      byte_nxt    = new_byte;
      bit_cnt_nxt = '0;
      pos_nxt     = '0;
      rest_nxt    = dig_q;
      showing_nxt = (dig_q != '0);
      over_nxt    = over_in;
    end else if (step) begin
      if (byte_end) begin
        if (pos_r == LAST_POS) begin
          busy_nxt = 1'b0;
        end else begin
          // next digit comes from what the previous byte left over
          pos_nxt     = POS_W'(pos_r + 1'b1);
          byte_nxt    = new_byte;
          bit_cnt_nxt = '0;
          rest_nxt    = dig_q;
          showing_nxt = showing_r && (dig_q != '0);
        end
      end else begin
        byte_nxt    = {byte_r[BYTE_W-2:0], 1'b0};
        bit_cnt_nxt = BIT_CNT_W'(bit_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      busy_r <= busy_nxt;
    end
    value_r   <= value_nxt;
    byte_r    <= byte_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    pos_r     <= pos_nxt;
    rest_r    <= rest_nxt;
    showing_r <= showing_nxt;
    over_r    <= over_nxt;
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, byte_r[BYTE_W-1]};
  assign out_tuser  = byte_end;
  assign out_tlast  = byte_end && (pos_r == LAST_POS);

endmodule

`default_nettype wire
